// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Key press classifier package
// Widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpc_pkg;

    localparam int KEY_W   = 16;
    localparam int CODE_W  = 32;
    localparam int KIND_W  = 2;
    localparam int TICK_W  = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_CODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_FLAG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_FLAG      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_FLAG      = 3'd5;

    localparam logic [KEY_W-1:0]  RST_IDLE_CODE      = 16'hFFFF;
    localparam logic [KEY_W-1:0]  RST_DEBOUNCE_TICKS = 16'd2;
    localparam logic [KEY_W-1:0]  RST_LONG_TICKS     = 16'd100;
    localparam logic [CODE_W-1:0] RST_SHORT_FLAG     = 32'h0001_0000;
    localparam logic [CODE_W-1:0] RST_LONG_FLAG      = 32'h0002_0000;
    localparam logic [CODE_W-1:0] RST_HOLD_FLAG      = 32'h0004_0000;

    typedef struct packed {
        logic [KEY_W-1:0]  idle_code;
        logic [KEY_W-1:0]  debounce_ticks;
        logic [KEY_W-1:0]  long_ticks;
        logic [CODE_W-1:0] short_flag;
        logic [CODE_W-1:0] long_flag;
        logic [CODE_W-1:0] hold_flag;
    } kpc_cfg_t;

endpackage

// ===== hw/rtl/kpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Key press classifier configuration registers
// Holds the six configuration registers written over the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kpc_cfg_regs
    import kpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    output kpc_cfg_t             cfg
);

    kpc_cfg_t cfg_reg;
    kpc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_IDLE_CODE:      cfg_next.idle_code      = cfg_data[KEY_W-1:0];
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = cfg_data[KEY_W-1:0];
                REG_LONG_TICKS:     cfg_next.long_ticks     = cfg_data[KEY_W-1:0];
                REG_SHORT_FLAG:     cfg_next.short_flag     = cfg_data;
                REG_LONG_FLAG:      cfg_next.long_flag      = cfg_data;
                REG_HOLD_FLAG:      cfg_next.hold_flag      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_code      <= RST_IDLE_CODE;
            cfg_reg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            cfg_reg.long_ticks     <= RST_LONG_TICKS;
            cfg_reg.short_flag     <= RST_SHORT_FLAG;
            cfg_reg.long_flag      <= RST_LONG_FLAG;
            cfg_reg.hold_flag      <= RST_HOLD_FLAG;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/kpc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Key press classifier input stage
// Input register with a skid entry so that the ready output is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kpc_in_stage
    import kpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_word,
    output logic             item_valid,
    output logic [KEY_W-1:0] item_word,
    input  logic             item_pop
);

    logic             main_valid_reg;
    logic             main_valid_next;
    logic [KEY_W-1:0] main_word_reg;
    logic [KEY_W-1:0] main_word_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [KEY_W-1:0] skid_word_reg;
    logic [KEY_W-1:0] skid_word_next;
    logic             s_accept;

    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign item_valid = main_valid_reg;
    assign item_word  = main_word_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_word_next  = main_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg) begin
            if (item_pop) begin
                main_word_next  = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_accept) begin
            if (!main_valid_reg || item_pop) begin
                main_valid_next = 1'b1;
                main_word_next  = s_word;
            end else begin
                skid_valid_next = 1'b1;
                skid_word_next  = s_word;
            end
        end else if (item_pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_word_reg <= main_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

// ===== hw/rtl/kpc_core.sv =====
// ----------------------------------------------------------------------------
// Key press classifier core
// Debounce and press classification state with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kpc_core
    import kpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  kpc_cfg_t          cfg,
    input  logic              item_valid,
    input  logic [KEY_W-1:0]  item_word,
    output logic              item_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CODE_W-1:0] m_code,
    output logic [KIND_W-1:0] m_kind
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DEB  = 2'd1;
    localparam logic [1:0] PH_PRESS = 2'd2;
    localparam logic [1:0] PH_HELD = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HOLD  = 2'd3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [KEY_W-1:0]  held_key_reg;
    logic [KEY_W-1:0]  held_key_next;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic [CODE_W-1:0] out_code_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [KIND_W-1:0] out_kind_next;

    logic              fire;
    logic [1:0]        phase_eff;
    logic [KEY_W-1:0]  held_eff;
    logic              release_key;
    logic [TICK_W-1:0] tick_inc;
    logic              over_debounce;
    logic              over_long;
    logic [CODE_W-1:0] key_ext;
    logic [CODE_W-1:0] held_ext;
    logic [CODE_W-1:0] code_calc;
    logic [KIND_W-1:0] kind_calc;

    assign fire     = item_valid && (!out_valid_reg || m_tready);
    assign item_pop = fire;
    assign m_tvalid = out_valid_reg;
    assign m_code   = out_code_reg;
    assign m_kind   = out_kind_reg;

    always_comb begin
        phase_eff = phase_reg;
        held_eff  = held_key_reg;
        if (phase_reg == PH_IDLE && item_word != cfg.idle_code) begin
            phase_eff = PH_DEB;
            held_eff  = item_word;
        end
        release_key   = (item_word != held_eff) || (item_word == cfg.idle_code);
        tick_inc      = (tick_count_reg != TICK_MAX) ? tick_count_reg + 1'b1
                                                     : tick_count_reg;
        over_debounce = tick_count_reg > {1'b0, cfg.debounce_ticks};
        over_long     = tick_count_reg > {1'b0, cfg.long_ticks};
        key_ext       = {{(CODE_W-KEY_W){1'b0}}, item_word};
        held_ext      = {{(CODE_W-KEY_W){1'b0}}, held_eff};

        phase_next      = phase_eff;
        held_key_next   = held_eff;
        tick_count_next = tick_count_reg;
        code_calc       = {{(CODE_W-KEY_W){1'b0}}, cfg.idle_code};
        kind_calc       = KIND_NONE;

        case (phase_eff)
            PH_DEB: begin
                if (release_key) begin
                    held_key_next   = cfg.idle_code;
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_inc;
                    if (over_debounce) begin
                        phase_next = PH_PRESS;
                    end
                end
            end
            PH_PRESS: begin
                if (release_key) begin
                    code_calc       = held_ext | cfg.short_flag;
                    kind_calc       = KIND_SHORT;
                    held_key_next   = cfg.idle_code;
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                end else if (over_long) begin
                    code_calc       = key_ext | cfg.long_flag;
                    kind_calc       = KIND_LONG;
                    phase_next      = PH_HELD;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            PH_HELD: begin
                if (release_key) begin
                    held_key_next = cfg.idle_code;
                    phase_next    = PH_IDLE;
                end else begin
                    code_calc = key_ext | cfg.hold_flag;
                    kind_calc = KIND_HOLD;
                end
            end
            default: begin
                phase_next = phase_eff;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_kind_next  = out_kind_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            out_code_next  = code_calc;
            out_kind_next  = kind_calc;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            held_key_reg   <= RST_IDLE_CODE;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                phase_reg      <= phase_next;
                held_key_reg   <= held_key_next;
                tick_count_reg <= tick_count_next;
            end
        end
        out_code_reg <= out_code_next;
        out_kind_reg <= out_kind_next;
    end

    `ASSERT_IMPLY(a_idle_count_clear, aclk, aresetn, phase_reg == PH_IDLE, tick_count_reg == '0)
    `ASSERT_IMPLY(a_held_count_clear, aclk, aresetn, phase_reg == PH_HELD, tick_count_reg == '0)
    `ASSERT_NEXT(a_long_enters_held, aclk, aresetn, fire && kind_calc == KIND_LONG, phase_reg == PH_HELD)
    `ASSERT_NEXT(a_short_returns_idle, aclk, aresetn, fire && kind_calc == KIND_SHORT, phase_reg == PH_IDLE)

endmodule

// ===== hw/rtl/key_press_classifier.sv =====
// ----------------------------------------------------------------------------
// Key press classifier
// Debounces a polled 16-bit button word and reports short presses, long
// presses and hold repeats.
// ----------------------------------------------------------------------------
// One button word is taken per clock cycle while the result side does not
// stall, and exactly one result leaves for each word: the word waits in the
// input register, then the debounce and press classification logic updates
// its state and loads the result register in the same cycle. A result of
// kind 0 carries the idle code. s_tready comes from a register, so a stall
// on the result side reaches the input in the following cycle, absorbed by
// a skid entry. Configuration writes are taken in every cycle and should
// only be made while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_press_classifier
    import kpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] button_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [31:0] event_code
    output logic [1:0]           m_tuser,   // [1:0] event_kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    kpc_cfg_t         cfg;
    logic             item_valid;
    logic [KEY_W-1:0] item_word;
    logic             item_pop;

    kpc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kpc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_tdata),
        .item_valid (item_valid),
        .item_word  (item_word),
        .item_pop   (item_pop)
    );

    kpc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_word  (item_word),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_code     (m_tdata),
        .m_kind     (m_tuser)
    );

endmodule
